/* src/agpl_pkg.sv */
// ----------------------------------------------------------------------------
// agpl_pkg
// Shared types, constants and helpers of the gain stage and peak limiter.
// ----------------------------------------------------------------------------
package agpl_pkg;

    localparam int LANES        = 8;
    localparam int LANE_W       = $clog2(LANES);
    localparam int SAMPLE_W     = 24;
    localparam int CHAN_W       = 4;
    localparam int LIN_GAIN_W   = 32;
    localparam int STEP_W       = 24;
    localparam int PRE_PROD_W   = SAMPLE_W + LIN_GAIN_W;
    localparam int PEAK_W       = PRE_PROD_W - 16;
    localparam int MAG_W        = PEAK_W + 1;
    localparam int GAIN_W       = 25;
    localparam int SUM_W        = MAG_W + 5;
    localparam int DVD_W        = 47;
    localparam int REM_W        = MAG_W;
    localparam int DIV_CNT_W    = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int MAX_CHANNELS_DEF = 8;

    localparam logic [GAIN_W-1:0]    UNITY_GAIN     = 25'd16777216;
    localparam logic [GAIN_W-1:0]    RELEASE_THRESH = 25'd16760439;
    localparam logic [PEAK_W-1:0]    PEAK_THRESH    = 40'd8380219;
    localparam logic [DVD_W-1:0]     ATTACK_NUM     = 47'd139330113471775;
    localparam logic [DIV_CNT_W-1:0] ATK_STEPS      = 6'd25;
    localparam logic [DIV_CNT_W-1:0] MONO_STEPS     = 6'd47;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CHANS    = 3'd0,
        CFG_GAIN_LINEAR  = 3'd1,
        CFG_RELEASE_STEP = 3'd2,
        CFG_LIMIT_ENABLE = 3'd3,
        CFG_MONO_ENABLE  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_PRE_END,
        S_DECIDE,
        S_DIV_ATK,
        S_REL_ADD,
        S_LIM,
        S_SUM,
        S_MONO_START,
        S_DIV_MONO,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              pre_mul;
        logic [LANE_W-1:0] lane;
        logic              atk_start;
        logic              atk_upd;
        logic              rel_mul;
        logic              rel_add;
        logic              lim;
        logic [1:0]        lim_phase;
        logic              sum_acc;
        logic              mono_start;
        logic              mono_fin;
        logic              out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic peak_over;
        logic rel_need;
        logic limit_en;
        logic mono_en;
        logic div_done;
        logic out_free;
    } t_stat;

    // sign and magnitude to saturated q1.23
    function automatic logic signed [SAMPLE_W-1:0] sat_sm(input logic neg,
                                                          input logic [DVD_W-1:0] mag);
        logic signed [SAMPLE_W-1:0] res;
        if (neg) begin
            if (mag >= DVD_W'(24'h800000)) res = 24'sh800000;
            else                           res = -$signed(mag[SAMPLE_W-1:0]);
        end else begin
            if (mag > DVD_W'(24'h7FFFFF)) res = 24'sh7FFFFF;
            else                          res = $signed(mag[SAMPLE_W-1:0]);
        end
        return res;
    endfunction

endpackage

/* src/agpl_in_if.sv */
// ----------------------------------------------------------------------------
// agpl_in_if
// Input frame channel: valid, ready and eight samples.
// ----------------------------------------------------------------------------
interface agpl_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_0;
    logic signed [23:0] sample_1;
    logic signed [23:0] sample_2;
    logic signed [23:0] sample_3;
    logic signed [23:0] sample_4;
    logic signed [23:0] sample_5;
    logic signed [23:0] sample_6;
    logic signed [23:0] sample_7;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                    sample_5, sample_6, sample_7, input ready);
    modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, sample_7, output ready);
endinterface

/* src/agpl_out_if.sv */
// ----------------------------------------------------------------------------
// agpl_out_if
// Result channel: valid, ready, eight outputs, peak flag and applied gain.
// ----------------------------------------------------------------------------
interface agpl_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] out_0;
    logic signed [23:0] out_1;
    logic signed [23:0] out_2;
    logic signed [23:0] out_3;
    logic signed [23:0] out_4;
    logic signed [23:0] out_5;
    logic signed [23:0] out_6;
    logic signed [23:0] out_7;
    logic               peak_over;
    logic [24:0]        current_gain;

    modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                    out_7, peak_over, current_gain, input ready);
    modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                  out_7, peak_over, current_gain, output ready);
endinterface

/* src/agpl_div.sv */
// ----------------------------------------------------------------------------
// agpl_div
// Restoring divider, one quotient bit per cycle, preloadable remainder.
// ----------------------------------------------------------------------------
module agpl_div
    import agpl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DVD_W-1:0]     i_dvd,
    input  logic [REM_W-1:0]     i_dsr,
    input  logic [REM_W-1:0]     i_rem_init,
    input  logic [DIV_CNT_W-1:0] i_steps,
    output logic                 o_done,
    output logic [DVD_W-1:0]     o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [DVD_W-1:0]     r_dvd, n_dvd;
    logic [DVD_W-1:0]     r_quot, n_quot;
    logic [REM_W-1:0]     r_dsr, n_dsr;
    logic [REM_W:0]       trial;
    logic                 fits;

    // one restoring step
    always_comb begin
        trial  = {r_rem, r_dvd[DVD_W-1]};
        fits   = trial >= {1'b0, r_dsr};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quot = r_quot;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
            n_rem  = i_rem_init;
            n_dvd  = i_dvd;
            n_quot = '0;
            n_dsr  = i_dsr;
        end else if (r_busy) begin
            n_rem  = fits ? REM_W'(trial - {1'b0, r_dsr}) : trial[REM_W-1:0];
            n_dvd  = {r_dvd[DVD_W-2:0], 1'b0};
            n_quot = {r_quot[DVD_W-2:0], fits};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_dsr  <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // a new division never starts over a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");

endmodule

/* src/agpl_ctrl.sv */
// ----------------------------------------------------------------------------
// agpl_ctrl
// Controller: sequences pre-gain, gain update, limiting, mono average, output.
// ----------------------------------------------------------------------------
module agpl_ctrl
    import agpl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [LANE_W-1:0]  r_cnt, n_cnt;
    logic [1:0]         r_ph, n_ph;
    logic               last_lane;

    assign last_lane = r_cnt == LANE_W'(LANES - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_ph           = r_ph;
        o_cmd          = '0;
        o_cmd.lane     = r_cnt;
        o_cmd.lim_phase = r_ph;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_PRE;
                end
            end
            S_PRE: begin
                o_cmd.pre_mul = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (last_lane) n_state = S_PRE_END;
            end
            S_PRE_END: n_state = S_DECIDE;
            S_DECIDE: begin
                n_cnt = '0;
                n_ph  = '0;
                if (!i_stat.limit_en) begin
                    n_state = i_stat.mono_en ? S_SUM : S_OUT;
                end else if (i_stat.peak_over) begin
                    o_cmd.atk_start = 1'b1;
                    n_state         = S_DIV_ATK;
                end else if (i_stat.rel_need) begin
                    o_cmd.rel_mul = 1'b1;
                    n_state       = S_REL_ADD;
                end else begin
                    n_state = S_LIM;
                end
            end
            S_DIV_ATK: begin
                if (i_stat.div_done) begin
                    o_cmd.atk_upd = 1'b1;
                    n_state       = S_LIM;
                end
            end
            S_REL_ADD: begin
                o_cmd.rel_add = 1'b1;
                n_state       = S_LIM;
            end
            S_LIM: begin
                o_cmd.lim = 1'b1;
                if (r_ph == 2'd2) begin
                    n_ph  = '0;
                    n_cnt = r_cnt + 1'b1;
                    if (last_lane) n_state = i_stat.mono_en ? S_SUM : S_OUT;
                end else begin
                    n_ph = r_ph + 1'b1;
                end
            end
            S_SUM: begin
                o_cmd.sum_acc = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (last_lane) n_state = S_MONO_START;
            end
            S_MONO_START: begin
                o_cmd.mono_start = 1'b1;
                n_state          = S_DIV_MONO;
            end
            S_DIV_MONO: begin
                if (i_stat.div_done) begin
                    o_cmd.mono_fin = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a frame taken in is followed by the pre-gain pass
    a_load_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load) |=> (r_state == S_PRE && r_cnt == '0))
        else $error("frame load not followed by pre-gain pass");

endmodule

/* src/agpl_dp.sv */
// ----------------------------------------------------------------------------
// agpl_dp
// Datapath: config registers, lane storage, shared multipliers, gain state.
// ----------------------------------------------------------------------------
module agpl_dp
    import agpl_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    agpl_in_if.sink               i_in,
    agpl_out_if.source            o_out,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);

    // configuration
    logic [CHAN_W-1:0]     r_num_chans;
    logic [LIN_GAIN_W-1:0] r_gain_lin;
    logic [STEP_W-1:0]     r_rel_step;
    logic                  r_limit_en;
    logic                  r_mono_en;

    // frame storage
    logic [SAMPLE_W-1:0]   r_x [LANES];
    logic                  r_neg [LANES];
    logic [MAG_W-1:0]      r_mag [LANES];
    logic [CHAN_W-1:0]     r_n;
    logic [PEAK_W-1:0]     r_peak;
    logic [PRE_PROD_W-1:0] r_prod;
    logic [LANE_W-1:0]     r_prod_lane;
    logic                  r_prod_vld;
    logic [GAIN_W-1:0]     r_gain;
    logic [STEP_W+GAIN_W-1:0] r_rel_prod;
    logic [44:0]           r_pp_lo;
    logic [45:0]           r_pp_hi;
    logic signed [SUM_W-1:0] r_sum;
    logic                  r_mono_neg;
    logic [DVD_W-1:0]      r_mono_q;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out [LANES];
    logic                       r_out_over;
    logic [GAIN_W-1:0]          r_out_gain;

    logic [SAMPLE_W-1:0]   x_sel, x_abs;
    logic [PEAK_W-1:0]     pre_mag;
    logic [MAG_W-1:0]      m_sel;
    logic [65:0]           lim_sum;
    logic [STEP_W+GAIN_W:0] rel_round;
    logic [GAIN_W+1:0]     rel_gain;
    logic [CHAN_W-1:0]     n_clamp;
    logic signed [SUM_W-1:0] lane_val;
    logic [SUM_W-1:0]      sum_abs;
    logic                  div_start, div_done;
    logic [DVD_W-1:0]      div_dvd, div_quot;
    logic [REM_W-1:0]      div_dsr, div_rem;
    logic [DIV_CNT_W-1:0]  div_steps;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_chans <= CHAN_W'(2);
            r_gain_lin  <= LIN_GAIN_W'(65536);
            r_rel_step  <= STEP_W'(175);
            r_limit_en  <= 1'b1;
            r_mono_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_CHANS:    r_num_chans <= i_cfg_data[CHAN_W-1:0];
                CFG_GAIN_LINEAR:  r_gain_lin  <= i_cfg_data[LIN_GAIN_W-1:0];
                CFG_RELEASE_STEP: r_rel_step  <= i_cfg_data[STEP_W-1:0];
                CFG_LIMIT_ENABLE: r_limit_en  <= i_cfg_data[0];
                CFG_MONO_ENABLE:  r_mono_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // channel count clamp
    always_comb begin
        if (r_num_chans == '0)                         n_clamp = CHAN_W'(1);
        else if (r_num_chans > CHAN_W'(MAX_CHANNELS))  n_clamp = CHAN_W'(MAX_CHANNELS);
        else                                           n_clamp = r_num_chans;
    end

    // lane selects and arithmetic
    always_comb begin
        x_sel    = r_x[i_cmd.lane];
        x_abs    = x_sel[SAMPLE_W-1] ? SAMPLE_W'(~x_sel + 1'b1) : x_sel;
        pre_mag  = r_prod[PRE_PROD_W-1:16];
        m_sel    = r_mag[i_cmd.lane];
        lim_sum  = {r_pp_hi, 20'b0} + 66'(r_pp_lo);
        rel_round = (STEP_W+GAIN_W+1)'(r_rel_prod) + (STEP_W+GAIN_W+1)'(24'hFFFFFF);
        rel_gain = (GAIN_W+2)'(r_gain) + (GAIN_W+2)'(rel_round[STEP_W+GAIN_W:24]);
        lane_val = r_neg[i_cmd.lane] ? -$signed(SUM_W'(m_sel)) : $signed(SUM_W'(m_sel));
        sum_abs  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    end

    // frame capture, pre-gain pass and limiting pass
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x[0] <= i_in.sample_0;
            r_x[1] <= i_in.sample_1;
            r_x[2] <= i_in.sample_2;
            r_x[3] <= i_in.sample_3;
            r_x[4] <= i_in.sample_4;
            r_x[5] <= i_in.sample_5;
            r_x[6] <= i_in.sample_6;
            r_x[7] <= i_in.sample_7;
            r_n    <= n_clamp;
            r_peak <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.pre_mul) begin
            r_prod      <= PRE_PROD_W'(x_abs) * PRE_PROD_W'(r_gain_lin);
            r_prod_lane <= i_cmd.lane;
            r_neg[i_cmd.lane] <= x_sel[SAMPLE_W-1];
        end
        if (r_prod_vld) begin
            r_mag[r_prod_lane] <= {1'b0, pre_mag};
            if (CHAN_W'(r_prod_lane) < r_n && pre_mag > r_peak) r_peak <= pre_mag;
        end
        if (i_cmd.rel_mul)
            r_rel_prod <= (STEP_W+GAIN_W)'(r_rel_step) * (STEP_W+GAIN_W)'(UNITY_GAIN - r_gain);
        if (i_cmd.lim) begin
            case (i_cmd.lim_phase)
                2'd0:    r_pp_lo <= 45'(m_sel[19:0]) * 45'(r_gain);
                2'd1:    r_pp_hi <= 46'(m_sel[MAG_W-1:20]) * 46'(r_gain);
                default: r_mag[i_cmd.lane] <= lim_sum[64:24];
            endcase
        end
        if (i_cmd.sum_acc && CHAN_W'(i_cmd.lane) < r_n)
            r_sum <= r_sum + lane_val;
        if (i_cmd.mono_fin) begin
            r_mono_neg <= r_sum[SUM_W-1];
            r_mono_q   <= div_quot;
        end
    end

    // limiter gain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_gain     <= UNITY_GAIN;
        end else begin
            r_prod_vld <= i_cmd.pre_mul;
            if (i_cmd.atk_upd && div_quot < DVD_W'(r_gain))
                r_gain <= div_quot[GAIN_W-1:0];
            else if (i_cmd.rel_add)
                r_gain <= (rel_gain > (GAIN_W+2)'(UNITY_GAIN)) ? UNITY_GAIN
                                                               : rel_gain[GAIN_W-1:0];
        end
    end

    // shared divider: attack candidate and mono average
    always_comb begin
        div_start = i_cmd.atk_start | i_cmd.mono_start;
        if (i_cmd.atk_start) begin
            div_dvd   = ATTACK_NUM << (DVD_W - ATK_STEPS);
            div_rem   = REM_W'(ATTACK_NUM >> ATK_STEPS);
            div_dsr   = REM_W'(r_peak);
            div_steps = ATK_STEPS;
        end else begin
            div_dvd   = DVD_W'(sum_abs);
            div_rem   = '0;
            div_dsr   = REM_W'(r_n);
            div_steps = MONO_STEPS;
        end
    end

    agpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dvd      (div_dvd),
        .i_dsr      (div_dsr),
        .i_rem_init (div_rem),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            for (int k = 0; k < LANES; k++) begin
                if (CHAN_W'(k) < r_n) r_out[k] <= sat_sm(r_neg[k], DVD_W'(r_mag[k]));
                else                  r_out[k] <= '0;
            end
            if (r_mono_en) r_out[0] <= sat_sm(r_mono_neg, r_mono_q);
            r_out_over <= r_limit_en && (r_peak > PEAK_THRESH);
            r_out_gain <= r_limit_en ? r_gain : UNITY_GAIN;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_0        = r_out[0];
    assign o_out.out_1        = r_out[1];
    assign o_out.out_2        = r_out[2];
    assign o_out.out_3        = r_out[3];
    assign o_out.out_4        = r_out[4];
    assign o_out.out_5        = r_out[5];
    assign o_out.out_6        = r_out[6];
    assign o_out.out_7        = r_out[7];
    assign o_out.peak_over    = r_out_over;
    assign o_out.current_gain = r_out_gain;

    // status to controller
    assign o_stat.peak_over = r_peak > PEAK_THRESH;
    assign o_stat.rel_need  = r_gain < RELEASE_THRESH;
    assign o_stat.limit_en  = r_limit_en;
    assign o_stat.mono_en   = r_mono_en;
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = !r_out_valid || o_out.ready;

    // limiter gain never rises above unity
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY_GAIN) else $error("limiter gain above unity");

    // a result is only written into a free output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || o_out.ready))
        else $error("output register overwritten");

endmodule

/* src/audio_gain_peak_limiter.sv */
// ----------------------------------------------------------------------------
// audio_gain_peak_limiter
// Pre-gain, instant-attack peak limiter with one-pole release, mono average.
// ----------------------------------------------------------------------------
// A new frame is accepted only in the idle state, once the result of the previous
//   frame has been loaded into the output register; the shared 8-lane multiplier
//   passes and the one-bit-per-cycle divider serve one frame at a time
// reset: synchronous active low, restores register defaults and unity gain
module audio_gain_peak_limiter
    import agpl_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    agpl_in_if.sink               i_in,
    agpl_out_if.source            o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    agpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    agpl_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

/* tb/sv/agpl_checker.sv */
// ----------------------------------------------------------------------------
// agpl_checker
// Watches the frame and result channels and the register port, predicts each
// processed frame and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module agpl_checker
    import agpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    agpl_in_if                    i_in,
    agpl_out_if                   i_out,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    typedef struct packed {
        logic [7:0][23:0] lane;
        logic             over;
        logic [24:0]      gain;
    } t_frame_res;

    // mirrored registers and limiter state
    logic [3:0]  num_chans;
    logic [31:0] gain_lin;
    logic [23:0] rel_step;
    logic        lim_en;
    logic        mono_en;
    logic [24:0] lim_gain;

    t_frame_res frames_due[$];

    function automatic longint sat24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // gain, limit and mix one frame; advances lim_gain
    function automatic t_frame_res limit_frame(input logic [7:0][23:0] s);
        t_frame_res   r;
        logic [63:0]  mag [8];
        logic         neg [8];
        longint       val [8];
        logic [63:0]  m, peak, cand, inc, g;
        longint       sum;
        int           n;
        peak = 0;
        r.over = 1'b0;
        g = 64'(UNITY_GAIN);
        n = (num_chans == 0) ? 1 : (num_chans > 8) ? 8 : int'(num_chans);
        for (int k = 0; k < 8; k++) begin
            neg[k] = s[k][23];
            m = neg[k] ? (64'h1000000 - 64'(s[k])) : 64'(s[k]);
            mag[k] = (m * 64'(gain_lin)) >> 16;
            if (k < n && mag[k] > peak) peak = mag[k];
        end
        if (lim_en) begin
            if (peak > 64'(PEAK_THRESH)) begin
                cand = 64'(ATTACK_NUM) / peak;
                r.over = 1'b1;
                if (cand < 64'(lim_gain)) lim_gain = cand[24:0];
            end else if (lim_gain < RELEASE_THRESH) begin
                inc = (64'(rel_step) * (64'(UNITY_GAIN) - 64'(lim_gain)) + 64'hFFFFFF) >> 24;
                g = 64'(lim_gain) + inc;
                if (g > 64'(UNITY_GAIN)) g = 64'(UNITY_GAIN);
                lim_gain = g[24:0];
            end
            g = 64'(lim_gain);
            for (int k = 0; k < 8; k++) mag[k] = (mag[k] * g) >> 24;
        end
        for (int k = 0; k < 8; k++) begin
            val[k] = neg[k] ? -longint'(mag[k]) : longint'(mag[k]);
            r.lane[k] = (k < n) ? 24'(sat24(val[k])) : 24'd0;
        end
        if (mono_en) begin
            sum = 0;
            for (int k = 0; k < n; k++) sum += val[k];
            r.lane[0] = 24'(sat24(sum / longint'(n)));
        end
        r.gain = g[24:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_frame_res exp_r;
        t_frame_res got;
        int         errs;
        errs = 0;
        if (!i_rst_n) begin
            num_chans <= 4'd2;
            gain_lin  <= 32'd65536;
            rel_step  <= 24'd175;
            lim_en    <= 1'b1;
            mono_en   <= 1'b0;
            lim_gain  = UNITY_GAIN;
            frames_due.delete();
            o_fail_cnt <= 0;
            o_pending  <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NUM_CHANS:    num_chans <= i_cfg_data[3:0];
                    CFG_GAIN_LINEAR:  gain_lin  <= i_cfg_data;
                    CFG_RELEASE_STEP: rel_step  <= i_cfg_data[23:0];
                    CFG_LIMIT_ENABLE: lim_en    <= i_cfg_data[0];
                    CFG_MONO_ENABLE:  mono_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // accepted frame beat
            if (i_in.valid && i_in.ready)
                frames_due.push_back(limit_frame({i_in.sample_7, i_in.sample_6,
                    i_in.sample_5, i_in.sample_4, i_in.sample_3, i_in.sample_2,
                    i_in.sample_1, i_in.sample_0}));
            // accepted result beat
            if (i_out.valid && i_out.ready) begin
                got.lane = {i_out.out_7, i_out.out_6, i_out.out_5, i_out.out_4,
                            i_out.out_3, i_out.out_2, i_out.out_1, i_out.out_0};
                got.over = i_out.peak_over;
                got.gain = i_out.current_gain;
                if (frames_due.size() == 0) begin
                    $error("result beat with no frame outstanding");
                    errs = errs + 1;
                end else begin
                    exp_r = frames_due.pop_front();
                    for (int k = 0; k < 8; k++)
                        if (got.lane[k] !== exp_r.lane[k]) begin
                            $error("out_%0d: expected %0d, got %0d", k,
                                   $signed(exp_r.lane[k]), $signed(got.lane[k]));
                            errs = errs + 1;
                        end
                    if (got.over !== exp_r.over) begin
                        $error("peak_over: expected %0d, got %0d", exp_r.over, got.over);
                        errs = errs + 1;
                    end
                    if (got.gain !== exp_r.gain) begin
                        $error("current_gain: expected %0d, got %0d", exp_r.gain, got.gain);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_cnt <= o_fail_cnt + errs;
            o_pending  <= frames_due.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives frames and register settings into the gain stage and peak limiter,
// stalls both channels at random and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import agpl_pkg::*;

    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_CYC  = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_cnt;
    int                    pending;
    int                    wdog = 0;
    logic                  no_idle = 1'b0;
    logic                  hold_req = 1'b0;

    agpl_in_if  in_ch ();
    agpl_out_if out_ch ();

    audio_gain_peak_limiter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    agpl_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch), .i_out(out_ch),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.sample_0, in_ch.sample_1, in_ch.sample_2, in_ch.sample_3} = '0;
        {in_ch.sample_4, in_ch.sample_5, in_ch.sample_6, in_ch.sample_7} = '0;
        out_ch.ready = 1'b0;
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int w;
        @(posedge i_clk);
        while (1) begin
            w = no_idle ? 0 : $urandom_range(0, 5);
            if (hold_req) w = 500;
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(negedge i_clk);
            while (!out_ch.valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop offering, let every outstanding frame come back, then some quiet cycles
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0][23:0] s);
        int w;
        w = no_idle ? 0 : $urandom_range(0, 5);
        if (w > 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.sample_0 <= s[0];
        in_ch.sample_1 <= s[1];
        in_ch.sample_2 <= s[2];
        in_ch.sample_3 <= s[3];
        in_ch.sample_4 <= s[4];
        in_ch.sample_5 <= s[5];
        in_ch.sample_6 <= s[6];
        in_ch.sample_7 <= s[7];
        @(negedge i_clk);
        while (!in_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // quiet, loud or fully random frame
    function automatic logic [7:0][23:0] rand_frame();
        logic [7:0][23:0] s;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 8; k++) begin
            if (kind < 4)      s[k] = 24'($signed($urandom_range(0, 524287)) - 262144);
            else if (kind < 7) s[k] = $urandom_range(0, 1) ? 24'h7FFFFF - 24'($urandom_range(0, 16384))
                                                           : 24'h800000 + 24'($urandom_range(0, 16384));
            else               s[k] = 24'($urandom);
        end
        return s;
    endfunction

    initial begin
        logic [7:0][23:0] s;
        logic [3:0]  ph_chans [12] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd3, 4'd8,
                                       4'd7, 4'd4, 4'd6, 4'd8};
        logic [31:0] ph_gain  [12] = '{32'd65536, 32'd0, 32'hFFFFFFFF, 32'd131072,
                                       32'd65536, 32'd40000, 32'd262144, 32'd98304,
                                       32'd0, 32'd65536, 32'd524288, 32'd70000};
        logic [23:0] ph_rel   [12] = '{24'd175, 24'hFFFFFF, 24'd0, 24'd100000,
                                       24'd2000000, 24'd175, 24'hFFFFFF, 24'd0,
                                       24'd50000, 24'd4000000, 24'd175, 24'd800000};
        logic        ph_lim   [12] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                                       1'b0, 1'b1, 1'b1, 1'b1};
        logic        ph_mono  [12] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                       1'b0, 1'b1, 1'b0, 1'b1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at reset settings
        send_frame('0);
        send_frame({8{24'h7FFFFF}});
        send_frame({8{24'h800000}});
        send_frame({4{24'h800000, 24'h7FFFFF}});
        send_frame({{6{24'd0}}, 24'd8380219, 24'd0});
        send_frame({{6{24'd0}}, 24'd0, 24'd8380220});
        send_frame({{6{24'd0}}, 24'hFFFFFF, 24'h000001});
        for (int i = 0; i < 8; i++) send_frame({8{24'h020000}});
        send_frame({{6{24'd0}}, 24'h800000, 24'h800001});
        settle();
        cfg_write(CFG_MONO_ENABLE, 32'd1);
        cfg_write(CFG_NUM_CHANS, 32'd8);
        send_frame({24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                    24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
        send_frame({8{24'h800000}});
        send_frame({24'h000003, {7{24'hFFFFFF}}});
        settle();

        // random phases over a sweep of settings
        for (int p = 0; p < 12; p++) begin
            cfg_write(CFG_NUM_CHANS, 32'(ph_chans[p]));
            cfg_write(CFG_GAIN_LINEAR, (p == 11) ? $urandom : ph_gain[p]);
            cfg_write(CFG_RELEASE_STEP, (p == 8) ? 32'($urandom_range(0, 24'hFFFFFF))
                                                 : 32'(ph_rel[p]));
            cfg_write(CFG_LIMIT_ENABLE, 32'(ph_lim[p]));
            cfg_write(CFG_MONO_ENABLE, 32'(ph_mono[p]));
            no_idle <= (p % 4 == 3);
            for (int i = 0; i < 160; i++) begin
                if (p == 2 && i == 20) hold_req <= 1'b1;
                if (p == 2 && i == 30) hold_req <= 1'b0;
                s = rand_frame();
                send_frame(s);
            end
            settle();
        end

        if (fail_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/agpl_pkg.sv
src/agpl_in_if.sv
src/agpl_out_if.sv
src/agpl_div.sv
src/agpl_ctrl.sv
src/agpl_dp.sv
src/audio_gain_peak_limiter.sv
tb/sv/agpl_checker.sv
tb/sv/tb_top.sv
